@@ sv/htrp_pkg.sv @@
// htrp_pkg: shared constants, stage structs and small arithmetic helpers
// for the tree route port block; no dependencies
package htrp_pkg;

    localparam int unsigned NODE_W = 15;
    localparam int unsigned PORT_W = 5;
    localparam int unsigned RND_W  = 16;
    localparam int unsigned LVL_W  = 3;

    localparam int unsigned PORTS_PER_SIDE   = 12;
    localparam int unsigned NODES_PER_MODULE = 32;
    localparam int unsigned MAX_PORT         = 23;

    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned ADDR_W     = 3;

    // register index taken from paddr[2]
    localparam logic CFG_IDX_LEVEL = 1'b0;

    localparam logic [LVL_W-1:0] LEVEL_RESET = 3'd1;

    // first stage: compares, quotients and digit sums
    typedef struct packed {
        logic       mod_eq;
        logic       clus_eq;
        logic [6:0] src_grp;
        logic [6:0] dst_grp;
        logic [2:0] src_quad;
        logic [2:0] dst_quad;
        logic       low_port;
        logic [4:0] sum12;
        logic [4:0] sum6;
        logic [1:0] rnd_lo;
        logic [4:0] dsum;
        logic [1:0] dst_sub;
        logic [4:0] dst_k;
    } front_t;

    // second stage: ancestor level and one candidate port per level
    typedef struct packed {
        logic [2:0]        anc;
        logic              low_port;
        logic [PORT_W-1:0] up_port;
        logic [3:0]        p1;
        logic [3:0]        p2;
        logic [3:0]        p3;
        logic [3:0]        p4;
        logic [5:0]        p5;
    } mid_t;

    // residue mod 3 of a small value by folding base-4 digits
    function automatic logic [1:0] mod3_u5(input logic [4:0] v);
        logic [3:0] t1;
        logic [2:0] t2;
        logic [2:0] t3;
        t1 = 4'(v[4:2]) + 4'(v[1:0]);
        t2 = 3'(t1[3:2]) + 3'(t1[1:0]);
        if (t2 >= 3'd3)
            t3 = t2 - 3'd3;
        else
            t3 = t2;
        return t3[1:0];
    endfunction

    // sum of the eight base-4 digits, same residue mod 3 as the value
    function automatic logic [4:0] digit_sum16(input logic [15:0] v);
        logic [4:0] acc;
        acc = '0;
        for (int i = 0; i < 8; i++)
            acc = acc + 5'(v[2*i +: 2]);
        return acc;
    endfunction

endpackage

@@ sv/htrp_cfg.sv @@
// htrp_cfg: apb register for the switch level
// depends on htrp_pkg
module htrp_cfg
    import htrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [LVL_W-1:0]  switch_level
);

    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == CFG_IDX_LEVEL);

    always_comb
    begin
        level_next = level_reg;
        if (wr_en)
        begin
            level_next = pwdata[LVL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= LEVEL_RESET;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

    always_comb
    begin
        if (paddr[2] == CFG_IDX_LEVEL)
            prdata = {29'd0, level_reg};
        else
            prdata = '0;
    end

    assign switch_level = level_reg;

endmodule

@@ sv/htrp_front.sv @@
// htrp_front: first pipeline stage, block compares, node quotients and
// digit sums of the random field and the destination; depends on htrp_pkg
module htrp_front
    import htrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NODE_W-1:0] source_node,
    input  logic [NODE_W-1:0] dest_node,
    input  logic [PORT_W-1:0] arrival_port,
    input  logic [RND_W-1:0]  random_value,
    output logic              out_valid,
    input  logic              out_ready,
    output front_t            out_data
);

    logic       valid_reg;
    logic       valid_next;
    front_t     data_reg;
    front_t     data_next;
    logic [15:0] src_prod;
    logic [15:0] dst_prod;
    logic [11:0] src_qprod;
    logic [11:0] dst_qprod;
    logic [1:0]  src_clus;
    logic [1:0]  dst_clus;

    assign in_ready = !valid_reg || out_ready;

    // node / 384 = (node >> 7) / 3, node / 4608 = (node >> 9) / 9
    assign src_prod  = 16'(source_node[14:7]) * 16'd171;
    assign dst_prod  = 16'(dest_node[14:7]) * 16'd171;
    assign src_qprod = 12'(source_node[14:9]) * 12'd57;
    assign dst_qprod = 12'(dest_node[14:9]) * 12'd57;

    // which 12-node cluster inside the module
    assign src_clus = (source_node[4:0] >= 5'd24) ? 2'd2 :
                      (source_node[4:0] >= 5'd12) ? 2'd1 : 2'd0;
    assign dst_clus = (dest_node[4:0] >= 5'd24) ? 2'd2 :
                      (dest_node[4:0] >= 5'd12) ? 2'd1 : 2'd0;

    always_comb
    begin
        data_next.mod_eq   = (source_node[14:5] == dest_node[14:5]);
        data_next.clus_eq  = (src_clus == dst_clus);
        data_next.src_grp  = src_prod[15:9];
        data_next.dst_grp  = dst_prod[15:9];
        data_next.src_quad = src_qprod[11:9];
        data_next.dst_quad = dst_qprod[11:9];
        data_next.low_port = (arrival_port < PORT_W'(PORTS_PER_SIDE));
        data_next.sum12    = digit_sum16({2'b00, random_value[15:2]});
        data_next.sum6     = digit_sum16({1'b0, random_value[15:1]});
        data_next.rnd_lo   = random_value[1:0];
        data_next.dsum     = digit_sum16({8'd0, dest_node[14:7]});
        data_next.dst_sub  = dest_node[6:5];
        data_next.dst_k    = dest_node[4:0];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/htrp_mid.sv @@
// htrp_mid: second pipeline stage, ancestor level and candidate ports
// depends on htrp_pkg
module htrp_mid
    import htrp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output mid_t   out_data
);

    logic       valid_reg;
    logic       valid_next;
    mid_t       data_reg;
    mid_t       data_next;
    logic [1:0] r12;
    logic [1:0] r6;
    logic [1:0] k_grp;
    logic [4:0] k_mod;

    assign in_ready = !valid_reg || out_ready;

    assign r12 = mod3_u5(in_data.sum12);
    assign r6  = mod3_u5(in_data.sum6);

    always_comb
    begin
        if (in_data.dst_k >= 5'd24)
        begin
            k_grp = 2'd2;
            k_mod = in_data.dst_k - 5'd24;
        end
        else if (in_data.dst_k >= 5'd12)
        begin
            k_grp = 2'd1;
            k_mod = in_data.dst_k - 5'd12;
        end
        else
        begin
            k_grp = 2'd0;
            k_mod = in_data.dst_k;
        end
    end

    always_comb
    begin
        if (in_data.mod_eq)
            data_next.anc = in_data.clus_eq ? 3'd1 : 3'd2;
        else if (in_data.src_grp == in_data.dst_grp)
            data_next.anc = 3'd3;
        else if (in_data.src_quad == in_data.dst_quad)
            data_next.anc = 3'd4;
        else
            data_next.anc = 3'd5;
        data_next.low_port = in_data.low_port;
        data_next.up_port  = PORT_W'(PORTS_PER_SIDE) + {1'b0, r12, in_data.rnd_lo};
        data_next.p1       = k_mod[3:0];
        data_next.p2       = {k_grp, in_data.rnd_lo};
        data_next.p3       = {mod3_u5({3'd0, in_data.dsum[1:0]} + 5'(in_data.dsum[4:2])),
                              in_data.dst_sub};
        data_next.p4       = {mod3_u5(in_data.dst_grp[6:2]), in_data.dst_grp[1:0]};
        // quad * 6 as two shifts
        data_next.p5       = 6'({r6, in_data.rnd_lo[0]})
                           + 6'({in_data.dst_quad, 2'b00})
                           + 6'({in_data.dst_quad, 1'b0});
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ sv/htrp_sel.sv @@
// htrp_sel: last pipeline stage, up or down choice by switch level, range
// check and the output register; depends on htrp_pkg
module htrp_sel
    import htrp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [LVL_W-1:0]  switch_level,
    input  logic              in_valid,
    output logic              in_ready,
    input  mid_t              in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PORT_W-1:0] exit_port,
    output logic              route_error
);

    logic              valid_reg;
    logic              valid_next;
    logic [PORT_W-1:0] port_reg;
    logic [PORT_W-1:0] port_next;
    logic              err_reg;
    logic              err_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        port_next = '0;
        err_next  = 1'b0;
        if (switch_level == 3'd0 || switch_level > 3'd5)
        begin
            err_next = 1'b1;
        end
        else if (switch_level < in_data.anc && in_data.low_port)
        begin
            port_next = in_data.up_port;
        end
        else
        begin
            unique case (switch_level)
                3'd1:    port_next = PORT_W'(in_data.p1);
                3'd2:    port_next = PORT_W'(in_data.p2);
                3'd3:    port_next = PORT_W'(in_data.p3);
                3'd4:    port_next = PORT_W'(in_data.p4);
                default:
                begin
                    // only the top level can land past the last port
                    if (in_data.p5 > 6'(MAX_PORT))
                        err_next = 1'b1;
                    else
                        port_next = in_data.p5[PORT_W-1:0];
                end
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            port_reg <= port_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid   = valid_reg;
    assign exit_port   = port_reg;
    assign route_error = err_reg;

endmodule

@@ sv/hierarchical_tree_route_port_top.sv @@
// Route port computation for one switch of a five-level up/down tree. Each
// request (source, destination, arrival port, random value) yields one exit
// port and an error flag. Throughput is one request per clock when m_tready
// does not stall the pipe; each request passes three register stages (block
// compares and node quotients, ancestor level and candidate ports, level
// select into the output register). Backpressure on m_tready stalls the
// stages in place; a stage with no valid request keeps taking new ones.
// switch_level is written over the apb port at address 0 and should only
// change while no request is in flight.
// depends on htrp_pkg, htrp_cfg, htrp_front, htrp_mid, htrp_sel
module hierarchical_tree_route_port_top
    import htrp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [14:0] source_node, [29:15] dest_node, [34:30] arrival_port,
    // [50:35] random_value, [55:51] zero
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [4:0] exit_port, [5] route_error, [7:6] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic [LVL_W-1:0]  switch_level;
    logic              front_valid;
    logic              front_ready;
    front_t            front_data;
    logic              mid_valid;
    logic              mid_ready;
    mid_t              mid_data;
    logic [PORT_W-1:0] exit_port;
    logic              route_error;

    htrp_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .switch_level (switch_level)
    );

    htrp_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .source_node  (s_tdata[14:0]),
        .dest_node    (s_tdata[29:15]),
        .arrival_port (s_tdata[34:30]),
        .random_value (s_tdata[50:35]),
        .out_valid    (front_valid),
        .out_ready    (front_ready),
        .out_data     (front_data)
    );

    htrp_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    htrp_sel u_sel (
        .clk          (clk),
        .rst_n        (rst_n),
        .switch_level (switch_level),
        .in_valid     (mid_valid),
        .in_ready     (mid_ready),
        .in_data      (mid_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .exit_port    (exit_port),
        .route_error  (route_error)
    );

    assign m_tdata = {2'b00, route_error, exit_port};

`ifndef SYNTHESIS
    // an error result always carries port zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && route_error |-> exit_port == '0)
        else $error("error result with nonzero port");

    // a good result never names a port past the last one
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !route_error |-> exit_port <= PORT_W'(MAX_PORT))
        else $error("exit port out of range");

    // an empty output stage means the whole pipe can take a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("pipe stalled with empty output stage");

    // below the top level no route can fall out of range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && switch_level >= 3'd1 && switch_level <= 3'd4 |-> !route_error)
        else $error("route error below top level");
`endif

endmodule
